[design/arht_pkg.sv]
// shared types, constants and helpers of the asid reference-count hash table
`default_nettype none
package arht_pkg;

	// default configuration
	localparam int SLOT_BITS_DEF = 7;
	localparam int NUM_TYPES_DEF = 4;
	localparam int COUNT_BITS_DEF = 16;
	localparam int MAX_SLOT_BITS = 10;

	// field widths
	localparam int PTB_W = 32;
	localparam int VM_W = 8;
	localparam int TYPE_W = 3;
	localparam int TAG_W = PTB_W + VM_W + TYPE_W;
	localparam int SIDE_W = 8;
	localparam int INDEX_W = 7;
	localparam int ASID_OUT_W = 7;
	localparam int STATUS_W = 3;

	// bit length helper widths
	localparam int PNUM_MAX_W = MAX_SLOT_BITS + 1;
	localparam int LEN_W = 4;

	// multiplicative hash constant
	localparam logic [PTB_W-1:0] HASH_MULT = 32'd2654435761;

	// operation codes
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_REUSED = 3'd0,
		ST_ALLOC = 3'd1,
		ST_FULL = 3'd2,
		ST_BAD_TYPE = 3'd3,
		ST_RELEASED = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_HOME_RD,
		S_HOME_WAIT,
		S_SCAN,
		S_COMMIT,
		S_HOP_WR,
		S_REL_RD,
		S_REL_WR,
		S_RESP
	} state_t;

	// number of significant bits of x
	function automatic logic [LEN_W-1:0] bit_len(input logic [PNUM_MAX_W-1:0] x);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < PNUM_MAX_W; i++) begin
			if (x[i]) begin
				n = LEN_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

[design/arht_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none
module arht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[design/asid_refcount_hash_table_core.sv]
// top level of the asid allocator: hashed, reference-counted table with probing
`default_nettype none
// Usage
// - input channel (in_valid / in_stall): one request per transfer; op acquire looks up
//   the tag {ptb, vm_index, trans_type} and reuses or allocates an asid, op release
//   decrements the count of entry_index
// - output channel (out_valid / out_stall): exactly one result transfer per request,
//   asid, status and invalidate, in request order
// - one request is worked on at a time; in_stall stays high from acceptance until the
//   result has been moved into the output register
// - release: passes S_REL_RD, S_REL_WR and S_RESP before out_valid; bad type: S_RESP only
// - acquire: passes S_HASH, S_HOME_RD, S_HOME_WAIT, then P probes in S_SCAN, then
//   S_COMMIT, S_HOP_WR when the home hop log is raised, and S_RESP; a full table goes
//   from S_SCAN straight to S_RESP; the probe walk streams one read a cycle through the
//   entry and count rams, so P is at most max(2^hop_log[home] + 1, 2^SLOT_BITS)
// - search for a tag and search for a free slot share one walk along the probe sequence
// - after reset a clearing pass writes zeros to every entry with in_stall held
//   high; contents are then all zero
// - a stalled output holds its result; the next request may be accepted meanwhile but
//   its result waits until the output register is free
module asid_refcount_hash_table_core #(
	parameter int SLOT_BITS = arht_pkg::SLOT_BITS_DEF,
	parameter int NUM_TYPES = arht_pkg::NUM_TYPES_DEF,
	parameter int COUNT_BITS = arht_pkg::COUNT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	// request channel
	input wire logic in_valid,
	output logic in_stall,
	input wire logic op,
	input wire logic [arht_pkg::PTB_W-1:0] ptb,
	input wire logic [arht_pkg::VM_W-1:0] vm_index,
	input wire logic [arht_pkg::TYPE_W-1:0] trans_type,
	input wire logic invalidate_on_reuse,
	input wire logic [arht_pkg::SIDE_W-1:0] extra_bits,
	input wire logic [arht_pkg::INDEX_W-1:0] entry_index,
	// result channel
	output logic out_valid,
	input wire logic out_stall,
	output logic [arht_pkg::ASID_OUT_W-1:0] asid,
	output logic [arht_pkg::STATUS_W-1:0] status,
	output logic invalidate
);

	localparam int DEPTH = 1 << SLOT_BITS;
	localparam int HOP_W = $clog2(SLOT_BITS + 1);
	// probe numbers run up to DEPTH + 1
	localparam int PW = SLOT_BITS + 1;
	localparam int ENT_W = arht_pkg::SIDE_W + arht_pkg::TAG_W;
	localparam int CNT_W = HOP_W + COUNT_BITS;
	localparam logic [PW-1:0] TABLE_SIZE_P = PW'(DEPTH);
	localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);

	arht_pkg::state_t state_q, state_d;

	// ram ports: entry ram {side, tag}, count ram {hop, count}
	logic m1_we, m2_we;
	logic [SLOT_BITS-1:0] m1_waddr, m2_waddr, raddr;
	logic [ENT_W-1:0] m1_wdata, m1_rdata;
	logic [CNT_W-1:0] m2_wdata, m2_rdata;

	// request registers
	logic [arht_pkg::TAG_W-1:0] tag_q;
	logic flag_q;
	logic [arht_pkg::SIDE_W-1:0] extra_q;
	logic [SLOT_BITS-1:0] rel_q;

	// home slot and probe state
	logic [arht_pkg::PTB_W-1:0] hash_prod;
	logic [SLOT_BITS-1:0] home_q, step;
	logic [HOP_W-1:0] hop_home_q;
	logic [COUNT_BITS-1:0] home_cnt_q;
	logic [PW-1:0] limit_q;
	logic [SLOT_BITS-1:0] idx_q, idx_s1;
	logic [PW-1:0] pnum_q, pnum_s1;
	logic v_s1;

	// first free slot seen on the walk
	logic free_found_q;
	logic [SLOT_BITS-1:0] free_idx_q;
	logic [HOP_W-1:0] free_hop_q;
	logic [PW-1:0] free_pnum_q;

	// selected slot for commit
	logic alloc_q;
	logic [SLOT_BITS-1:0] sel_idx_q;
	logic [HOP_W-1:0] sel_hop_q;
	logic [COUNT_BITS-1:0] sel_cnt_q;
	logic [PW-1:0] sel_pnum_q;
	logic [arht_pkg::LEN_W-1:0] sel_len;
	logic raise;

	// pending result and output register
	logic [arht_pkg::ASID_OUT_W-1:0] res_asid_q, asid_q;
	arht_pkg::status_t res_status_q, status_q;
	logic res_inv_q, inv_q, out_valid_q;
	logic out_free;

	logic [SLOT_BITS-1:0] clr_q;

	logic [HOP_W-1:0] hop_rd;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic free_here, search_last, free_last;
	logic scan_hit, scan_alloc, scan_full;
	logic accept, bad_type;

	arht_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_entry_ram (
		.clk(clk),
		.we(m1_we),
		.waddr(m1_waddr),
		.wdata(m1_wdata),
		.raddr(raddr),
		.rdata(m1_rdata)
	);

	arht_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_count_ram (
		.clk(clk),
		.we(m2_we),
		.waddr(m2_waddr),
		.wdata(m2_wdata),
		.raddr(raddr),
		.rdata(m2_rdata)
	);

	assign in_stall = (state_q != arht_pkg::S_IDLE);
	assign accept = in_valid && !in_stall;
	assign bad_type = int'(trans_type) >= NUM_TYPES;
	assign out_free = !out_valid_q || !out_stall;

	// multiplicative hash, top bits of the low product word
	assign hash_prod = ptb_q_mul(tag_q);
	function automatic logic [arht_pkg::PTB_W-1:0] ptb_q_mul(
		input logic [arht_pkg::TAG_W-1:0] t);
		logic [arht_pkg::PTB_W-1:0] p;
		p = t[arht_pkg::TAG_W-1 -: arht_pkg::PTB_W];
		return p * arht_pkg::HASH_MULT;
	endfunction

	assign step = home_q | SLOT_BITS'(1);
	assign hop_rd = m2_rdata[CNT_W-1 -: HOP_W];
	assign cnt_rd = m2_rdata[COUNT_BITS-1:0];

	// bit length of the claimed distance raises the home hop log
	assign sel_len = arht_pkg::bit_len(arht_pkg::PNUM_MAX_W'(sel_pnum_q));
	assign raise = sel_len > arht_pkg::LEN_W'(hop_home_q);

	// probe check on data of probe pnum_s1
	always_comb begin
		search_last = pnum_s1 >= limit_q;
		free_last = pnum_s1 >= LAST_P;
		free_here = v_s1 && (pnum_s1 < TABLE_SIZE_P) && (cnt_rd == '0);
		scan_hit = v_s1 && (pnum_s1 <= limit_q) &&
			(m1_rdata[arht_pkg::TAG_W-1:0] == tag_q);
		scan_alloc = v_s1 && !scan_hit && search_last && (free_found_q || free_here);
		scan_full = v_s1 && !scan_hit && search_last && free_last &&
			!free_found_q && !free_here;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			arht_pkg::S_CLEAR: begin
				if (clr_q == '1) state_d = arht_pkg::S_IDLE;
			end
			arht_pkg::S_IDLE: begin
				if (accept) begin
					if (op == arht_pkg::OP_RELEASE) state_d = arht_pkg::S_REL_RD;
					else if (bad_type) state_d = arht_pkg::S_RESP;
					else state_d = arht_pkg::S_HASH;
				end
			end
			arht_pkg::S_HASH: state_d = arht_pkg::S_HOME_RD;
			arht_pkg::S_HOME_RD: state_d = arht_pkg::S_HOME_WAIT;
			arht_pkg::S_HOME_WAIT: state_d = arht_pkg::S_SCAN;
			arht_pkg::S_SCAN: begin
				if (scan_hit || scan_alloc) state_d = arht_pkg::S_COMMIT;
				else if (scan_full) state_d = arht_pkg::S_RESP;
			end
			arht_pkg::S_COMMIT: begin
				if (alloc_q && raise) state_d = arht_pkg::S_HOP_WR;
				else state_d = arht_pkg::S_RESP;
			end
			arht_pkg::S_HOP_WR: state_d = arht_pkg::S_RESP;
			arht_pkg::S_REL_RD: state_d = arht_pkg::S_REL_WR;
			arht_pkg::S_REL_WR: state_d = arht_pkg::S_RESP;
			arht_pkg::S_RESP: begin
				if (out_free) state_d = arht_pkg::S_IDLE;
			end
			default: state_d = arht_pkg::S_CLEAR;
		endcase
	end

	// ram control
	always_comb begin
		m1_we = 1'b0;
		m1_waddr = sel_idx_q;
		m1_wdata = {extra_q, tag_q};
		m2_we = 1'b0;
		m2_waddr = sel_idx_q;
		m2_wdata = {sel_hop_q, sel_cnt_q};
		raddr = idx_q;
		case (state_q)
			arht_pkg::S_CLEAR: begin
				m1_we = 1'b1;
				m1_waddr = clr_q;
				m1_wdata = '0;
				m2_we = 1'b1;
				m2_waddr = clr_q;
				m2_wdata = '0;
			end
			arht_pkg::S_HOME_RD: raddr = home_q;
			arht_pkg::S_REL_RD: raddr = rel_q;
			arht_pkg::S_REL_WR: begin
				m2_we = 1'b1;
				m2_waddr = rel_q;
				m2_wdata = {hop_rd, cnt_rd - COUNT_BITS'(1)};
			end
			arht_pkg::S_COMMIT: begin
				m2_we = 1'b1;
				if (alloc_q) begin
					m1_we = 1'b1;
					m2_wdata = {sel_hop_q, COUNT_BITS'(1)};
				end
			end
			arht_pkg::S_HOP_WR: begin
				// claimed slot differs from home whenever the log is raised
				m2_we = 1'b1;
				m2_waddr = home_q;
				m2_wdata = {HOP_W'(sel_len), home_cnt_q};
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arht_pkg::S_CLEAR;
			clr_q <= '0;
			v_s1 <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == arht_pkg::S_CLEAR) clr_q <= clr_q + SLOT_BITS'(1);
			v_s1 <= (state_q == arht_pkg::S_SCAN) && (state_d == arht_pkg::S_SCAN);
			if (state_q == arht_pkg::S_HOME_WAIT) free_found_q <= 1'b0;
			else if (state_q == arht_pkg::S_SCAN && free_here) free_found_q <= 1'b1;
			if (state_q == arht_pkg::S_RESP && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			arht_pkg::S_IDLE: begin
				if (accept) begin
					tag_q <= {ptb, vm_index, trans_type};
					flag_q <= invalidate_on_reuse;
					extra_q <= extra_bits;
					rel_q <= SLOT_BITS'(entry_index);
					res_asid_q <= '0;
					res_status_q <= arht_pkg::ST_BAD_TYPE;
					res_inv_q <= 1'b0;
				end
			end
			arht_pkg::S_HASH: begin
				home_q <= hash_prod[arht_pkg::PTB_W-1 -: SLOT_BITS];
			end
			arht_pkg::S_HOME_WAIT: begin
				hop_home_q <= hop_rd;
				home_cnt_q <= cnt_rd;
				limit_q <= PW'(1) << hop_rd;
				idx_q <= home_q;
				pnum_q <= '0;
			end
			arht_pkg::S_SCAN: begin
				// one read issued per cycle along the probe sequence
				idx_q <= idx_q + step;
				pnum_q <= pnum_q + PW'(1);
				idx_s1 <= idx_q;
				pnum_s1 <= pnum_q;
				if (free_here && !free_found_q) begin
					free_idx_q <= idx_s1;
					free_hop_q <= hop_rd;
					free_pnum_q <= pnum_s1;
				end
				if (scan_hit) begin
					alloc_q <= 1'b0;
					sel_idx_q <= idx_s1;
					sel_hop_q <= hop_rd;
					sel_cnt_q <= cnt_rd + COUNT_BITS'(1);
				end else if (scan_alloc) begin
					alloc_q <= 1'b1;
					sel_idx_q <= free_found_q ? free_idx_q : idx_s1;
					sel_hop_q <= free_found_q ? free_hop_q : hop_rd;
					sel_pnum_q <= free_found_q ? free_pnum_q : pnum_s1;
				end else if (scan_full) begin
					res_asid_q <= '0;
					res_status_q <= arht_pkg::ST_FULL;
					res_inv_q <= 1'b0;
				end
			end
			arht_pkg::S_COMMIT: begin
				res_asid_q <= arht_pkg::ASID_OUT_W'(sel_idx_q);
				res_status_q <= alloc_q ? arht_pkg::ST_ALLOC : arht_pkg::ST_REUSED;
				res_inv_q <= alloc_q ? 1'b1 : flag_q;
			end
			arht_pkg::S_REL_WR: begin
				res_asid_q <= arht_pkg::ASID_OUT_W'(rel_q);
				res_status_q <= arht_pkg::ST_RELEASED;
				res_inv_q <= 1'b0;
			end
			arht_pkg::S_RESP: begin
				if (out_free) begin
					asid_q <= res_asid_q;
					status_q <= res_status_q;
					inv_q <= res_inv_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign asid = asid_q;
	assign status = status_q;
	assign invalidate = inv_q;

	// the walk decides by the last probe it needs
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arht_pkg::S_SCAN && v_s1) |-> (pnum_s1 <= TABLE_SIZE_P))
		else $error("probe walk ran past the table");

	// entry ram is written only by the clearing pass or an allocation
	a_entry_write: assert property (@(posedge clk) disable iff (!arst_n)
		m1_we |-> (state_q == arht_pkg::S_CLEAR ||
			(state_q == arht_pkg::S_COMMIT && alloc_q)))
		else $error("unexpected entry ram write");

	// one request at a time
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted while busy");

	// a finished result reaches the output register
	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arht_pkg::S_RESP && out_free) |=> (out_valid && !in_stall))
		else $error("result not published");

endmodule
`default_nettype wire

[sim/arht_tb_pkg.sv]
`timescale 1ns / 1ps
// scoreboard class: models the asid table and checks results in order
package arht_tb_pkg;
	import arht_pkg::*;

	localparam int SLOTS = 1 << SLOT_BITS_DEF;

	typedef struct packed {
		logic [ASID_OUT_W-1:0] asid;
		status_t status;
		logic invalidate;
	} grant_t;

	class asid_table_scoreboard;
		logic [PTB_W-1:0] tag_ptb [SLOTS];
		logic [VM_W-1:0] tag_vm [SLOTS];
		logic [TYPE_W-1:0] tag_ty [SLOTS];
		logic [COUNT_BITS_DEF-1:0] refs [SLOTS];
		logic [SIDE_W-1:0] side [SLOTS];
		int unsigned hops [SLOTS];
		grant_t due_grants [$];
		int unsigned held [$];
		int errors;

		function new();
			for (int k = 0; k < SLOTS; k++) begin
				tag_ptb[k] = '0;
				tag_vm[k] = '0;
				tag_ty[k] = '0;
				refs[k] = '0;
				side[k] = '0;
				hops[k] = 0;
			end
			errors = 0;
		endfunction

		function grant_t acquire(logic [PTB_W-1:0] p, logic [VM_W-1:0] vm,
				logic [TYPE_W-1:0] ty, logic inv, logic [SIDE_W-1:0] extra);
			grant_t g;
			logic [PTB_W-1:0] prod;
			int unsigned home, stride, slot, span, walk, len, w, n;
			g = '{'0, ST_BAD_TYPE, 1'b0};
			if (ty >= NUM_TYPES_DEF) begin
				return g;
			end
			prod = p * HASH_MULT;
			home = prod >> (PTB_W - SLOT_BITS_DEF);
			stride = home | 1;
			// tag search along the probe sequence, bounded by the home hop log
			span = 1 << hops[home];
			slot = home;
			for (n = 0; n <= span; n++) begin
				if (tag_ptb[slot] == p && tag_vm[slot] == vm && tag_ty[slot] == ty) begin
					refs[slot] = refs[slot] + 1'b1;
					g = '{ASID_OUT_W'(slot), ST_REUSED, inv};
					return g;
				end
				slot = (slot + stride) % SLOTS;
			end
			// first free slot on the same sequence
			slot = home;
			walk = 0;
			while (refs[slot] != 0) begin
				walk++;
				slot = (slot + stride) % SLOTS;
				if (walk >= SLOTS) begin
					g = '{'0, ST_FULL, 1'b0};
					return g;
				end
			end
			len = 0;
			w = walk;
			while (w != 0) begin
				len++;
				w >>= 1;
			end
			if (len > hops[home]) begin
				hops[home] = len;
			end
			tag_ptb[slot] = p;
			tag_vm[slot] = vm;
			tag_ty[slot] = ty;
			refs[slot] = 1;
			side[slot] = extra;
			g = '{ASID_OUT_W'(slot), ST_ALLOC, 1'b1};
			return g;
		endfunction

		function void log_request(logic o, logic [PTB_W-1:0] p, logic [VM_W-1:0] vm,
				logic [TYPE_W-1:0] ty, logic inv, logic [SIDE_W-1:0] extra,
				logic [INDEX_W-1:0] idx);
			grant_t g;
			int unsigned rel;
			if (o == OP_RELEASE) begin
				rel = idx % SLOTS;
				refs[rel] = refs[rel] - 1'b1;
				g = '{ASID_OUT_W'(rel), ST_RELEASED, 1'b0};
			end else begin
				g = acquire(p, vm, ty, inv, extra);
				if (g.status == ST_ALLOC || g.status == ST_REUSED) begin
					held.push_back(g.asid);
				end
			end
			due_grants.push_back(g);
		endfunction

		function void check_result(logic [ASID_OUT_W-1:0] a, logic [STATUS_W-1:0] st,
				logic inv);
			grant_t g;
			if (due_grants.size() == 0) begin
				$display("%0t: result with nothing outstanding, asid %0d status %0d",
					$time, a, st);
				errors++;
				return;
			end
			g = due_grants.pop_front();
			if (g.asid !== a) begin
				$display("%0t: asid mismatch, expected %0d, got %0d", $time, g.asid, a);
				errors++;
			end
			if (g.status !== st) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time, g.status, st);
				errors++;
			end
			if (g.invalidate !== inv) begin
				$display("%0t: invalidate mismatch, expected %0d, got %0d", $time,
					g.invalidate, inv);
				errors++;
			end
		endfunction

		// hand back one held asid for release, -1 when none
		function int take_held();
			int k, a;
			if (held.size() == 0) begin
				return -1;
			end
			k = $urandom_range(0, held.size() - 1);
			a = held[k];
			held.delete(k);
			return a;
		endfunction

		function int pending();
			return due_grants.size();
		endfunction
	endclass

endpackage

[sim/tb_asid_refcount_hash_table_core.sv]
`timescale 1ns / 1ps
// testbench top: drives acquire and release transfers and checks every result
module tb_asid_refcount_hash_table_core;
	import arht_pkg::*;
	import arht_tb_pkg::*;

	// cycles with no transfer on either channel before the run is declared hung;
	// worst acquire walks the whole table plus stalls and gaps
	localparam int IDLE_LIMIT = 5000;
	localparam int BASES = 16;
	localparam int POOL = BASES * 4;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic op;
	logic [PTB_W-1:0] ptb;
	logic [VM_W-1:0] vm_index;
	logic [TYPE_W-1:0] trans_type;
	logic invalidate_on_reuse;
	logic [SIDE_W-1:0] extra_bits;
	logic [INDEX_W-1:0] entry_index;
	logic out_valid;
	logic out_stall;
	logic [ASID_OUT_W-1:0] asid;
	logic [STATUS_W-1:0] status;
	logic invalidate;

	asid_table_scoreboard sb;

	// tag pool: 16 base addresses, each shared by three guest/type variants,
	// so tags collide on the same home slot and probe chains get long
	logic [PTB_W-1:0] pool_ptb [POOL];
	logic [VM_W-1:0] pool_vm [POOL];
	logic [TYPE_W-1:0] pool_ty [POOL];

	int quiet = 0;
	int stall_run = 0;
	int burst_left = 0;

	asid_refcount_hash_table_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.ptb(ptb),
		.vm_index(vm_index),
		.trans_type(trans_type),
		.invalidate_on_reuse(invalidate_on_reuse),
		.extra_bits(extra_bits),
		.entry_index(entry_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.asid(asid),
		.status(status),
		.invalidate(invalidate)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result monitor: every output transfer goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(asid, status, invalidate);
		end
	end

	// hang detector, counts cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= IDLE_LIMIT) begin
			$display("asid_refcount_hash_table_core regression: fail");
			$finish;
		end
	end

	// receiver back-pressure: long open stretches, short bursts, and stall runs
	always @(negedge clk) begin
		if (stall_run == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					out_stall = 1'b0;
					stall_run = $urandom_range(20, 60);
				end
				1, 2: begin
					out_stall = 1'b0;
					stall_run = $urandom_range(1, 4);
				end
				default: begin
					out_stall = 1'b1;
					stall_run = $urandom_range(1, 6);
				end
			endcase
		end else begin
			stall_run--;
		end
	end

	// present one request at a falling edge and hold it until the transfer
	task automatic send(input logic o, input logic [PTB_W-1:0] p, input logic [VM_W-1:0] vm,
			input logic [TYPE_W-1:0] ty, input logic inv, input logic [SIDE_W-1:0] ex,
			input logic [INDEX_W-1:0] idx);
		op = o;
		ptb = p;
		vm_index = vm;
		trans_type = ty;
		invalidate_on_reuse = inv;
		extra_bits = ex;
		entry_index = idx;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.log_request(o, p, vm, ty, inv, ex, idx);
		@(negedge clk);
		// sender bursts: valid stays high inside a burst, drops for a gap after it
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
		end
	endtask

	// release ignores everything but the index, so the rest is noise
	task automatic send_release(input int idx);
		send(OP_RELEASE, PTB_W'($urandom), VM_W'($urandom), TYPE_W'($urandom),
			1'($urandom), SIDE_W'($urandom), INDEX_W'(idx));
	endtask

	task automatic send_acquire(input logic [PTB_W-1:0] p, input logic [VM_W-1:0] vm,
			input logic [TYPE_W-1:0] ty, input logic inv, input logic [SIDE_W-1:0] ex);
		send(OP_ACQUIRE, p, vm, ty, inv, ex, INDEX_W'($urandom));
	endtask

	// hold the sender until every outstanding result has come back
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// one random request; weights in percent, the remainder acquires a pool tag
	task automatic random_item(input int w_rel, input int w_new, input int w_bad);
		int pick, held_asid, t;
		pick = $urandom_range(0, 99);
		held_asid = -1;
		t = $urandom_range(0, POOL - 1);
		if ($urandom_range(0, 99) == 0) begin
			// stray release of any slot, may wrap a zero count
			send_release($urandom_range(0, SLOTS - 1));
		end else begin
			if (pick < w_rel) begin
				held_asid = sb.take_held();
			end
			if (held_asid >= 0) begin
				send_release(held_asid);
			end else if (pick >= w_rel && pick < w_rel + w_new) begin
				send_acquire(PTB_W'($urandom), VM_W'($urandom),
					TYPE_W'($urandom_range(0, NUM_TYPES_DEF - 1)), 1'($urandom),
					SIDE_W'($urandom));
			end else if (pick >= w_rel + w_new && pick < w_rel + w_new + w_bad) begin
				send_acquire(PTB_W'($urandom), VM_W'($urandom),
					TYPE_W'($urandom_range(NUM_TYPES_DEF, 7)), 1'($urandom),
					SIDE_W'($urandom));
			end else begin
				send_acquire(pool_ptb[t], pool_vm[t], pool_ty[t], 1'($urandom),
					SIDE_W'($urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		op = OP_ACQUIRE;
		ptb = '0;
		vm_index = '0;
		trans_type = '0;
		invalidate_on_reuse = 1'b0;
		extra_bits = '0;
		entry_index = '0;
		for (int b = 0; b < BASES; b++) begin
			for (int v = 0; v < 4; v++) begin
				pool_ptb[b * 4 + v] = $urandom;
				pool_vm[b * 4 + v] = VM_W'($urandom);
				pool_ty[b * 4 + v] = TYPE_W'($urandom_range(0, NUM_TYPES_DEF - 1));
			end
			pool_ptb[b * 4 + 1] = pool_ptb[b * 4];
			pool_ptb[b * 4 + 2] = pool_ptb[b * 4];
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the core clears its table first; in_stall covers that, no wait needed here

		// all-zero tag matches slot 0 even though it was never allocated
		send_acquire('0, '0, '0, 1'b1, '0);
		send_acquire('0, '0, '0, 1'b0, 8'hff);
		// count 2 down to 0, then a release of a zero count wraps to all ones
		send_release(0);
		send_release(0);
		send_release(0);
		// all-ones count increments back to zero
		send_acquire('0, '0, '0, 1'b1, '0);
		// field extremes, allocate then reuse with and without invalidate
		send_acquire('1, '1, TYPE_W'(NUM_TYPES_DEF - 1), 1'b0, '1);
		send_acquire('1, '1, TYPE_W'(NUM_TYPES_DEF - 1), 1'b1, '0);
		send_acquire('1, '1, TYPE_W'(NUM_TYPES_DEF - 1), 1'b0, '0);
		// bad translation types leave the table alone
		send_acquire('1, '1, TYPE_W'(NUM_TYPES_DEF), 1'b1, '1);
		send_acquire(32'h8000_0000, 8'h80, 3'd7, 1'b1, 8'h80);
		// same base, different guest: same home slot, next probe
		send_acquire(32'h8000_0000, 8'h80, 3'd1, 1'b1, 8'h00);
		send_acquire(32'h8000_0000, 8'h7f, 3'd1, 1'b0, 8'h5a);
		send_acquire(32'h8000_0000, 8'h01, 3'd2, 1'b1, 8'ha5);
		send_acquire(32'h8000_0000, 8'h7f, 3'd1, 1'b1, 8'h11);
		// top index and a release of a never-used slot
		send_release(SLOTS - 1);
		send(OP_RELEASE, '1, '1, '1, 1'b1, '1, '1);
		send_acquire(32'h0000_0001, 8'h01, 3'd2, 1'b1, 8'hc3);
		send_release(1);
		settle();

		// balanced traffic around the tag pool
		repeat (700) random_item(45, 8, 5);
		settle();
		// mostly fresh tags and only stray releases: the table fills and reports full
		repeat (300) random_item(0, 85, 5);
		settle();
		// drain the held entries, slots go free again
		repeat (300) random_item(80, 5, 5);
		settle();
		repeat (700) random_item(40, 10, 5);
		settle();

		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("asid_refcount_hash_table_core regression: pass");
		end else begin
			$display("asid_refcount_hash_table_core regression: fail");
		end
		$finish;
	end

endmodule
